[src/pmr_pkg.sv]
// ----------------------------------------------------------------------------
// pmr_pkg - shared types and constants for the palette recolor block
// Field widths, stream word layout and register indexes.
// ----------------------------------------------------------------------------
package pmr_pkg;

   // field widths
   localparam int COLOR_W       = 24;
   localparam int COLUMN_W      = 5;
   localparam int ENTRY_FIELD_W = 5;
   localparam int TARGET_W      = 6;
   localparam int SCHEME_W      = 3;

   // request word layout, lowest bit first
   localparam int PIX_COLOR_LSB = 0;
   localparam int COLUMN_LSB    = PIX_COLOR_LSB + COLOR_W;
   localparam int ENTRY_LSB     = COLUMN_LSB + COLUMN_W;
   localparam int TARGET_LSB    = ENTRY_LSB + ENTRY_FIELD_W;
   localparam int TBL_COLOR_LSB = TARGET_LSB + TARGET_W;
   localparam int REQ_TDATA_W   = 64;

   // response word layout
   localparam int RSP_TDATA_W   = 32;
   localparam int RSP_TUSER_W   = SCHEME_W + 1;

   // register port
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 6;

   // table target code for the match color store
   localparam logic [TARGET_W-1:0] TARGET_MATCH = '0;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_TABLE = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_COLORS  = 2'd0,
      CSR_PLAYER_PALETTE = 2'd1,
      CSR_EXPAND_SCHEMES = 2'd2,
      CSR_MIRROR         = 2'd3
   } csr_idx_type;

endpackage

[src/pmr_ram.sv]
// ----------------------------------------------------------------------------
// pmr_ram - replacement color store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pmr_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 24,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/palette_match_recolor.sv]
// ----------------------------------------------------------------------------
// palette_match_recolor - sprite pixel recolor through a match palette
// Matches pixel colors against a palette and emits per-scheme replacements.
// ----------------------------------------------------------------------------
// Request words are either pixels (tuser = pixel) or table writes (tuser =
// table). A table write fills one match color (target 0) or one replacement
// color (target player*SCHEME_COUNT+scheme+1) and gives no response. A pixel
// is compared against the first active_colors match entries; the lowest
// matching entry wins. On a hit the response carries that entry's
// replacement color for each scheme of the selected player, otherwise the
// original color is repeated. With expand_schemes set a pixel gives
// SCHEME_COUNT response words (scheme 0 up, tlast on the final one), else
// one. Pipeline: six register stages (input, compare, priority encode,
// scheme expander, RAM read, output). The scheme expander issues one
// replacement RAM read per cycle while the RAM read stage is free: an
// expanded pixel holds it until all its schemes are read, and unexpanded
// pixels pass at one per cycle unless the output stalls. Tables come up
// unwritten after reset and there is no clearing pass: only entries that
// have been written may be hit. Registers must be written only while the
// block is idle: a rule for the user, the block does not enforce it.
// ----------------------------------------------------------------------------
module palette_match_recolor #(
   parameter int PALETTE_ENTRIES = 32,
   parameter int SCHEME_COUNT    = 8,
   parameter int PLAYER_SETS     = 4,
   parameter int SPRITE_WIDTH    = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_color, column, table_entry, table_target, table_color
   input  logic [pmr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // kind
   input  logic                              req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_color, out_column, zero pad
   output logic [pmr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // scheme_index, matched
   output logic [pmr_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   // register write port
   input  logic                              csr_we,
   input  logic [pmr_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [pmr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import pmr_pkg::*;

   localparam int ENTRY_W    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int CNT_W      = $clog2(PALETTE_ENTRIES + 1);
   localparam int SETS       = PLAYER_SETS * SCHEME_COUNT;
   localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int REPL_DEPTH = SETS * PALETTE_ENTRIES;
   localparam int ADDR_W     = (REPL_DEPTH > 1) ? $clog2(REPL_DEPTH) : 1;
   localparam int SCH_W      = (SCHEME_COUNT > 1) ? $clog2(SCHEME_COUNT) : 1;
   localparam logic [COLUMN_W-1:0] MIRROR_BASE =
      COLUMN_W'((SPRITE_WIDTH - 1) % (1 << COLUMN_W));

   // item flowing through the front stages
   typedef struct packed {
      logic                is_table;
      logic                wr_match;   // table write into match store
      logic                wr_repl;    // table write into replacement store
      logic [ENTRY_W-1:0]  entry;
      logic [ADDR_W-1:0]   wr_addr;
      logic [COLOR_W-1:0]  color;      // pixel color or table color
      logic [COLUMN_W-1:0] dcol;
      logic [ENTRY_W-1:0]  hit;
      logic                found;
   } item_type;

   // one response word in flight
   typedef struct packed {
      logic [COLOR_W-1:0]  color;
      logic [COLUMN_W-1:0] dcol;
      logic [SCH_W-1:0]    scheme;
      logic                found;
      logic                last;
   } word_type;

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] cnt_ff, cnt_in;     // active entries, saturated
   logic [SET_W-1:0] base_ff, base_in;   // first replacement set of player
   logic             expand_ff;
   logic             mirror_ff;

   always_comb begin
      logic [1:0] ply;
      ply = csr_wdata[1:0];
      // player index modulo PLAYER_SETS; value is at most 3
      for (int i = 0; i < 3; i++) begin
         if (int'(ply) >= PLAYER_SETS) begin
            ply = ply - 2'(PLAYER_SETS);
         end
      end
      base_in = SET_W'(ply) * SET_W'(SCHEME_COUNT);
      cnt_in  = (int'(csr_wdata) > PALETTE_ENTRIES) ? CNT_W'(PALETTE_ENTRIES)
                                                     : CNT_W'(csr_wdata);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         base_ff   <= '0;
         expand_ff <= 1'b0;
         mirror_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ACTIVE_COLORS:  cnt_ff    <= cnt_in;
            CSR_PLAYER_PALETTE: base_ff   <= base_in;
            CSR_EXPAND_SCHEMES: expand_ff <= csr_wdata[0];
            CSR_MIRROR:         mirror_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // pipeline control: each stage takes a new word when empty or draining
   // ---------------------------------------------------------------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic free0, free1, free2, free3, free4, free5;
   logic move0, move1, move2, move4;
   logic issue, done3, accept;
   logic [SCH_W-1:0] k_ff, k_in, last_k;

   assign last_k = expand_ff ? SCH_W'(SCHEME_COUNT - 1) : '0;

   item_type s0_ff, s1_ff, s2_ff, s3_ff;
   item_type s0_in, s2_in;

   always_comb begin
      free5  = !v5_ff || rsp_tready;
      move4  = v4_ff && free5;
      free4  = !v4_ff || free5;
      // expander sends one scheme per cycle into the RAM read stage while it is free
      issue  = v3_ff && !s3_ff.is_table && free4;
      done3  = v3_ff && (s3_ff.is_table || (free4 && (k_ff == last_k)));
      free3  = !v3_ff || done3;
      move2  = v2_ff && free3;
      free2  = !v2_ff || free3;
      move1  = v1_ff && free2;
      free1  = !v1_ff || free2;
      move0  = v0_ff && free1;
      free0  = !v0_ff || free1;
      accept = req_tvalid && free0;
   end

   assign req_tready = free0;

   always_comb begin
      if (move2) begin
         k_in = '0;
      end else if (issue) begin
         k_in = SCH_W'(k_ff + 1'b1);
      end else begin
         k_in = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         k_ff  <= '0;
      end else begin
         if (free0) v0_ff <= req_tvalid;
         if (free1) v1_ff <= v0_ff;
         if (free2) v2_ff <= v1_ff;
         if (free3) v3_ff <= v2_ff;
         if (free4) v4_ff <= issue;
         if (free5) v5_ff <= v4_ff;
         k_ff <= k_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 0: input decode
   // ---------------------------------------------------------------------
   logic [ENTRY_FIELD_W-1:0] f_entry;
   logic [TARGET_W-1:0]      f_target;
   logic [COLUMN_W-1:0]      f_column;
   logic [SET_W-1:0]         wr_set;
   logic                     entry_ok;

   always_comb begin
      f_entry  = req_tdata[ENTRY_LSB +: ENTRY_FIELD_W];
      f_target = req_tdata[TARGET_LSB +: TARGET_W];
      f_column = req_tdata[COLUMN_LSB +: COLUMN_W];
      entry_ok = int'(f_entry) < PALETTE_ENTRIES;
      wr_set   = SET_W'(f_target - 1'b1);

      s0_in          = '0;
      s0_in.is_table = (req_tuser != KIND_PIXEL);
      s0_in.wr_match = s0_in.is_table && entry_ok && (f_target == TARGET_MATCH);
      s0_in.wr_repl  = s0_in.is_table && entry_ok && (f_target != TARGET_MATCH)
                       && (int'(f_target) <= SETS);
      s0_in.entry    = ENTRY_W'(f_entry);
      s0_in.wr_addr  = ADDR_W'(wr_set) * ADDR_W'(PALETTE_ENTRIES) + ADDR_W'(s0_in.entry);
      s0_in.color    = s0_in.is_table ? req_tdata[TBL_COLOR_LSB +: COLOR_W]
                                      : req_tdata[PIX_COLOR_LSB +: COLOR_W];
      s0_in.dcol     = mirror_ff ? COLUMN_W'(MIRROR_BASE - f_column) : f_column;
   end

   // ---------------------------------------------------------------------
   // stage 1: compare against the first active_colors match entries
   // match store is written in order as table writes leave stage 0
   // ---------------------------------------------------------------------
   logic [COLOR_W-1:0]         match_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] eq_ff, eq_in;

   always_comb begin
      for (int m = 0; m < PALETTE_ENTRIES; m++) begin
         eq_in[m] = !s0_ff.is_table && (CNT_W'(m) < cnt_ff)
                    && (match_ff[m] == s0_ff.color);
      end
   end

   always_ff @(posedge clock) begin
      if (move0 && s0_ff.wr_match) begin
         match_ff[s0_ff.entry] <= s0_ff.color;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: lowest matching entry wins
   // ---------------------------------------------------------------------
   always_comb begin
      s2_in       = s1_ff;
      s2_in.hit   = '0;
      s2_in.found = 1'b0;
      for (int m = PALETTE_ENTRIES - 1; m >= 0; m--) begin
         if (eq_ff[m]) begin
            s2_in.hit   = ENTRY_W'(m);
            s2_in.found = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: scheme expander, drives the replacement RAM
   // ---------------------------------------------------------------------
   logic [SET_W-1:0]   rd_set;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [COLOR_W-1:0] ram_rdata;
   logic               ram_we;
   word_type           s4_ff, s4_in, s5_ff, s5_in;

   always_comb begin
      rd_set       = SET_W'(base_ff + SET_W'(k_ff));
      ram_raddr    = ADDR_W'(rd_set) * ADDR_W'(PALETTE_ENTRIES) + ADDR_W'(s3_ff.hit);
      ram_we       = v3_ff && s3_ff.wr_repl;
      s4_in.color  = s3_ff.color;
      s4_in.dcol   = s3_ff.dcol;
      s4_in.scheme = k_ff;
      s4_in.found  = s3_ff.found;
      s4_in.last   = (k_ff == last_k);
   end

   pmr_ram #(
      .DEPTH  (REPL_DEPTH),
      .DATA_W (COLOR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s3_ff.wr_addr),
      .wr_data (s3_ff.color),
      .rd_en   (issue),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------
   // stage 4 -> output: pick replacement or pass-through color
   // ---------------------------------------------------------------------
   always_comb begin
      s5_in       = s4_ff;
      s5_in.color = s4_ff.found ? ram_rdata : s4_ff.color;
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) s0_ff <= s0_in;
      if (move0) begin
         s1_ff <= s0_ff;
         eq_ff <= eq_in;
      end
      if (move1) s2_ff <= s2_in;
      if (move2) s3_ff <= s2_ff;
      if (issue) s4_ff <= s4_in;
      if (move4) s5_ff <= s5_in;
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = RSP_TDATA_W'({s5_ff.dcol, s5_ff.color});
   assign rsp_tuser  = {s5_ff.found, SCHEME_W'(s5_ff.scheme)};
   assign rsp_tlast  = s5_ff.last;

endmodule

[src/pmr_checker.sv]
// ----------------------------------------------------------------------------
// pmr_checker - port-level checks for palette_match_recolor
// Watches the response stream for scheme ordering and run consistency.
// ----------------------------------------------------------------------------
module pmr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pmr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [pmr_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input logic                              rsp_tlast,
   input logic                              csr_we,
   input logic [pmr_pkg::CSR_IDX_W-1:0]     csr_addr,
   input logic [pmr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import pmr_pkg::*;

   logic                rsp_fire;
   logic                expand_ff;
   logic [SCHEME_W-1:0] exp_scheme_ff;
   logic                in_run_ff;
   logic [COLUMN_W-1:0] run_col_ff;
   logic                run_match_ff;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         expand_ff     <= 1'b0;
         exp_scheme_ff <= '0;
         in_run_ff     <= 1'b0;
      end else begin
         if (csr_we && (csr_addr == CSR_EXPAND_SCHEMES)) begin
            expand_ff <= csr_wdata[0];
         end
         if (rsp_fire) begin
            exp_scheme_ff <= rsp_tlast ? '0 : SCHEME_W'(rsp_tuser[SCHEME_W-1:0] + 1'b1);
            in_run_ff     <= !rsp_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         run_col_ff   <= rsp_tdata[COLOR_W +: COLUMN_W];
         run_match_ff <= rsp_tuser[SCHEME_W];
      end
   end

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // schemes of one pixel count up from zero
   a_scheme_order: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_tuser[SCHEME_W-1:0] == exp_scheme_ff)
      else $error("scheme index out of order");

   // without expansion every pixel is a single word
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !expand_ff |-> rsp_tlast)
      else $error("multi-word pixel with expansion off");

   // column and match flag stay fixed across one pixel's words
   a_run_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && in_run_ff |-> rsp_tdata[COLOR_W +: COLUMN_W] == run_col_ff
                                && rsp_tuser[SCHEME_W] == run_match_ff)
      else $error("column or match flag changed within a pixel");

endmodule

bind palette_match_recolor pmr_checker u_pmr_checker (.*);
